>>> rtl/mcrm_pkg.sv
`timescale 1ns / 1ps

package mcrm_pkg;

    // sizing of the node table and the send rings
    localparam int NUM_NODES    = 16;
    localparam int BUFFER_BYTES = 32768;
    localparam int RING_SLOTS   = 4;

    localparam int NODE_W    = 4;
    localparam int NODE_AW   = $clog2(NUM_NODES);
    localparam int SLOT_W    = $clog2(RING_SLOTS);
    localparam int OFS_W     = 16;
    localparam int MSG_W     = 14;
    localparam int TIME_W    = 48;
    localparam int ADDR_W    = 23;
    localparam int PAY_W     = 15;
    localparam int HDR_W     = 8;
    localparam int TOT_W     = 17;
    localparam int BUF_SHIFT = $clog2(BUFFER_BYTES);

    localparam logic [MSG_W-1:0] MSGS_MAX = {MSG_W{1'b1}};

    // up to three result beats per command
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    localparam int FILL_W = RING_SLOTS + 2 * SLOT_W + MSG_W + OFS_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = CFG_IDX_W'(5);

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_REPLY = 2'd1,
        CMD_POLL  = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_PLACED     = 2'd0,
        KIND_DISPATCHED = 2'd1,
        KIND_BUSY       = 2'd2,
        KIND_TOO_LARGE  = 2'd3
    } t_kind;

    // per-node ring and fill word
    typedef struct packed {
        logic [RING_SLOTS-1:0] replies;
        logic [SLOT_W-1:0]     tail;
        logic [SLOT_W-1:0]     head;
        logic [MSG_W-1:0]      msgs;
        logic [OFS_W-1:0]      offset;
    } t_fill;

    typedef struct packed {
        t_cmd              cmd;
        logic [NODE_W-1:0] node;
        logic [PAY_W-1:0]  payload;
        logic [1:0]        blk;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [OFS_W-1:0]  byte_th;
        logic [MSG_W-1:0]  count_th;
        logic [TIME_W-1:0] max_age;
        logic [HDR_W-1:0]  header;
        logic [3:0]        own_node;
        logic [4:0]        active_nodes;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [NODE_W-1:0] dest_node;
        logic [1:0]        slot;
        logic [OFS_W-1:0]  byte_count;
        logic [ADDR_W-1:0] local_address;
        logic [ADDR_W-1:0] remote_address;
    } t_result;

endpackage

>>> rtl/mcrm_ram.sv
`timescale 1ns / 1ps

module mcrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/mcrm_update.sv
`timescale 1ns / 1ps

module mcrm_update
    import mcrm_pkg::*;
(
    input  t_item                  i_item,
    input  t_cfg                   i_cfg,
    input  t_fill                  i_fill,
    input  logic [TIME_W-1:0]      i_oldest,
    input  logic                   i_age_hit,
    input  logic                   i_too_large,
    input  logic                   i_need_force,
    input  logic [TOT_W-1:0]       i_total,
    output t_result                o_res [MAX_RES],
    output logic [RES_CNT_W-1:0]   o_res_cnt,
    output logic                   o_wr,
    output t_fill                  o_fill,
    output logic [TIME_W-1:0]      o_oldest
);

    function automatic logic [SLOT_W-1:0] f_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    function automatic t_result f_disp_res(input t_fill f, input logic [NODE_W-1:0] n,
                                           input logic [ADDR_W-1:0] bl,
                                           input logic [ADDR_W-1:0] br);
        t_result r;
        r                = t_result'('0);
        r.kind           = KIND_DISPATCHED;
        r.dest_node      = n;
        r.slot           = 2'(f.head);
        r.byte_count     = f.offset;
        r.local_address  = bl;
        r.remote_address = br;
        return r;
    endfunction

    function automatic t_fill f_disp_fill(input t_fill f);
        t_fill g;
        g                 = f;
        g.replies[f.head] = 1'b0;
        g.head            = f_inc(f.head);
        g.offset          = '0;
        g.msgs            = '0;
        return g;
    endfunction

    logic [ADDR_W-1:0]    base_l;
    logic [ADDR_W-1:0]    base_r;
    logic                 disp_ok;
    logic                 hit;
    logic                 age2;
    logic                 auto_hit;
    logic [RES_CNT_W-1:0] k;
    t_fill                f1;
    t_fill                f2;

    // buffer base addresses in the outbound and inbound areas
    assign base_l = ADDR_W'((ADDR_W'(i_cfg.own_node) * ADDR_W'(i_cfg.active_nodes)
                    + ADDR_W'(i_item.node)) << BUF_SHIFT);
    assign base_r = ADDR_W'((ADDR_W'(i_item.node) * ADDR_W'(i_cfg.active_nodes)
                    + ADDR_W'(i_cfg.own_node)) << BUF_SHIFT);

    // head buffer holds something and the ring has a free slot
    assign disp_ok = (i_fill.msgs != '0) && (f_inc(i_fill.head) != i_fill.tail);
    assign hit     = (i_fill.offset >= i_cfg.byte_th) || (i_fill.msgs >= i_cfg.count_th)
                     || i_age_hit;

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            o_res[i] = t_result'('0);
        end
        o_res_cnt = '0;
        o_wr      = 1'b0;
        o_fill    = i_fill;
        o_oldest  = i_oldest;
        f1        = i_fill;
        f2        = i_fill;
        k         = '0;
        age2      = 1'b0;
        auto_hit  = 1'b0;

        case (i_item.cmd)
            CMD_SEND: begin
                if (i_too_large) begin
                    o_res[0].kind      = KIND_TOO_LARGE;
                    o_res[0].dest_node = i_item.node;
                    o_res_cnt          = RES_CNT_W'(1);
                end else if (i_need_force && !disp_ok) begin
                    o_res[0].kind       = KIND_BUSY;
                    o_res[0].dest_node  = i_item.node;
                    o_res[0].slot       = 2'(i_fill.head);
                    o_res[0].byte_count = i_fill.offset;
                    o_res_cnt           = RES_CNT_W'(1);
                end else begin
                    // forced dispatch to make room
                    if (i_need_force) begin
                        o_res[0] = f_disp_res(i_fill, i_item.node, base_l, base_r);
                        f1       = f_disp_fill(i_fill);
                        k        = RES_CNT_W'(1);
                    end
                    o_res[k].kind          = KIND_PLACED;
                    o_res[k].dest_node     = i_item.node;
                    o_res[k].slot          = 2'(f1.head);
                    o_res[k].byte_count    = f1.offset;
                    o_res[k].local_address = ADDR_W'(base_l + ADDR_W'(f1.offset));
                    k                      = RES_CNT_W'(k + 1'b1);

                    f2        = f1;
                    f2.offset = OFS_W'(TOT_W'(f1.offset) + i_total);
                    if (f1.msgs != MSGS_MAX) begin
                        f2.msgs = MSG_W'(f1.msgs + 1'b1);
                    end
                    // first message of the buffer restarts the age at zero
                    if (f1.msgs == '0) begin
                        o_oldest = i_item.now;
                        age2     = (i_cfg.max_age == '0);
                    end else begin
                        age2     = i_age_hit;
                    end
                    auto_hit = (f_inc(f2.head) != f2.tail)
                               && ((f2.offset >= i_cfg.byte_th)
                                   || (f2.msgs >= i_cfg.count_th) || age2);
                    o_fill = f2;
                    if (auto_hit) begin
                        o_res[k] = f_disp_res(f2, i_item.node, base_l, base_r);
                        o_fill   = f_disp_fill(f2);
                        k        = RES_CNT_W'(k + 1'b1);
                    end
                    o_res_cnt = k;
                    o_wr      = 1'b1;
                end
            end
            CMD_REPLY: begin
                if (32'(i_item.blk) < RING_SLOTS) begin
                    f1.replies[SLOT_W'(i_item.blk)] = 1'b1;
                    // retire acknowledged slots from the tail
                    for (int i = 0; i < RING_SLOTS - 1; i++) begin
                        if (f1.tail != f1.head && f1.replies[f1.tail]) begin
                            f1.tail = f_inc(f1.tail);
                        end
                    end
                    o_fill = f1;
                    o_wr   = 1'b1;
                end
            end
            CMD_POLL: begin
                if (disp_ok && hit) begin
                    o_res[0]  = f_disp_res(i_fill, i_item.node, base_l, base_r);
                    o_fill    = f_disp_fill(i_fill);
                    o_res_cnt = RES_CNT_W'(1);
                    o_wr      = 1'b1;
                end
            end
            default: begin
                // flush: age cleared, dispatch forced
                o_oldest = '0;
                o_wr     = 1'b1;
                if (disp_ok) begin
                    o_res[0]  = f_disp_res(i_fill, i_item.node, base_l, base_r);
                    o_fill    = f_disp_fill(i_fill);
                    o_res_cnt = RES_CNT_W'(1);
                end
            end
        endcase
    end

endmodule

>>> rtl/message_coalescing_ring_manager.sv
`timescale 1ns / 1ps

// message coalescing ring manager: per destination node a ring of send buffers
// (head, tail, reply marks) and the fill of the head buffer (bytes, message
// count, oldest time) live in two 16-entry synchronous memories. every command
// beat does one read-modify-write of its node: the beat is taken in the idle
// state, the memories answer in the read state, where the age and room checks
// are registered, and the calc state builds the results and writes the node
// back. result beats follow in the output state, one per cycle while the sink is
// ready; a command gives 0 to 3 result beats. a new command is taken only after
// the last result beat of the previous one has been delivered, which also keeps
// accesses to one node from overlapping.
// results per command: send gives placed (with an optional forced dispatch in
// front and an automatic dispatch behind), busy or too large; poll and flush
// give at most one dispatch; a reply gives nothing. tlast marks the final
// result beat of a command. the node table comes out of reset empty through
// per-entry valid bits, so no clearing pass is needed. configuration writes are
// always taken (ready tied high) and must only happen while the block is idle.

module message_coalescing_ring_manager
    import mcrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [71:0]          s_axis_tdata,   // node, payload_bytes, reply_block, now
    input  logic [1:0]           s_axis_tuser,   // command
    // result channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,   // dest_node, slot, byte_count,
                                                 // local_address, remote_address
    output logic [1:0]           m_axis_tuser,   // kind
    output logic                 m_axis_tlast,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    localparam int OUT_BITS = NODE_W + 2 + OFS_W + 2 * ADDR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_OUT
    } t_state;

    t_state               r_state;
    t_item                r_item;
    t_cfg                 r_cfg;
    t_fill                r_fill;
    logic [TIME_W-1:0]    r_oldest;
    logic                 r_age_hit;
    logic                 r_too_large;
    logic                 r_need_force;
    logic [TOT_W-1:0]     r_total;
    logic [NUM_NODES-1:0] r_valid;
    t_result              r_res [MAX_RES];
    logic [RES_CNT_W-1:0] r_res_cnt;
    logic [RES_CNT_W-1:0] r_res_idx;

    logic                 s_fire;
    logic                 m_fire;
    logic                 res_last;
    t_item                in_item;
    logic [FILL_W-1:0]    fill_q;
    logic [TIME_W-1:0]    oldest_q;
    t_fill                fill_rd;
    logic [TIME_W-1:0]    oldest_rd;
    logic [TIME_W-1:0]    age;
    logic [TOT_W-1:0]     total;
    t_result              n_res [MAX_RES];
    logic [RES_CNT_W-1:0] n_res_cnt;
    logic                 n_wr;
    t_fill                n_fill;
    logic [TIME_W-1:0]    n_oldest;
    logic                 ram_we;
    t_result              out_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // unpack the command beat
    always_comb begin
        in_item.cmd     = t_cmd'(s_axis_tuser);
        in_item.node    = s_axis_tdata[3:0];
        in_item.payload = s_axis_tdata[18:4];
        in_item.blk     = s_axis_tdata[20:19];
        in_item.now     = s_axis_tdata[68:21];
    end

    // node table: ring and fill word, and oldest message time
    assign ram_we = (r_state == S_CALC) && n_wr;

    mcrm_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NUM_NODES)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_item.node[NODE_AW-1:0]),
        .i_wdata (n_fill),
        .i_re    (s_fire),
        .i_raddr (in_item.node[NODE_AW-1:0]),
        .o_rdata (fill_q)
    );

    mcrm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_NODES)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_item.node[NODE_AW-1:0]),
        .i_wdata (n_oldest),
        .i_re    (s_fire),
        .i_raddr (in_item.node[NODE_AW-1:0]),
        .o_rdata (oldest_q)
    );

    // never-written entries read as the reset value (all zero)
    assign fill_rd   = r_valid[r_item.node[NODE_AW-1:0]] ? t_fill'(fill_q) : t_fill'('0);
    assign oldest_rd = r_valid[r_item.node[NODE_AW-1:0]] ? oldest_q : '0;
    assign age       = TIME_W'(r_item.now - oldest_rd);
    assign total     = TOT_W'(r_cfg.header) + TOT_W'(r_item.payload);

    mcrm_update u_update (
        .i_item       (r_item),
        .i_cfg        (r_cfg),
        .i_fill       (r_fill),
        .i_oldest     (r_oldest),
        .i_age_hit    (r_age_hit),
        .i_too_large  (r_too_large),
        .i_need_force (r_need_force),
        .i_total      (r_total),
        .o_res        (n_res),
        .o_res_cnt    (n_res_cnt),
        .o_wr         (n_wr),
        .o_fill       (n_fill),
        .o_oldest     (n_oldest)
    );

    // result beat currently on the bus
    assign out_res      = r_res[r_res_idx];
    assign res_last     = (r_res_idx == RES_CNT_W'(r_res_cnt - 1'b1));
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = res_last;
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tdata  = {(72 - OUT_BITS)'(0), out_res.remote_address,
                            out_res.local_address, out_res.byte_count,
                            out_res.slot, out_res.dest_node};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_th      <= OFS_W'(16384);
            r_cfg.count_th     <= MSG_W'(8417);
            r_cfg.max_age      <= TIME_W'(50000);
            r_cfg.header       <= HDR_W'(24);
            r_cfg.own_node     <= '0;
            r_cfg.active_nodes <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BYTE_TH:  r_cfg.byte_th      <= i_cfg_data[OFS_W-1:0];
                CFG_COUNT_TH: r_cfg.count_th     <= i_cfg_data[MSG_W-1:0];
                CFG_MAX_AGE:  r_cfg.max_age      <= i_cfg_data;
                CFG_HEADER:   r_cfg.header       <= i_cfg_data[HDR_W-1:0];
                CFG_OWN_NODE: r_cfg.own_node     <= i_cfg_data[3:0];
                CFG_ACTIVE:   r_cfg.active_nodes <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: accept, read, update and write back, deliver result beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_res_cnt <= '0;
            r_res_idx <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_item <= in_item;
                        // nodes beyond the table are dropped silently
                        if (32'(in_item.node) < NUM_NODES) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_fill       <= fill_rd;
                    r_oldest     <= oldest_rd;
                    r_total      <= total;
                    r_age_hit    <= (age >= r_cfg.max_age);
                    r_too_large  <= (total >= TOT_W'(BUFFER_BYTES));
                    r_need_force <= ((TOT_W'(fill_rd.offset) + total) > TOT_W'(BUFFER_BYTES));
                    r_state      <= S_CALC;
                end
                S_CALC: begin
                    if (n_wr) begin
                        r_valid[r_item.node[NODE_AW-1:0]] <= 1'b1;
                    end
                    r_res     <= n_res;
                    r_res_cnt <= n_res_cnt;
                    r_res_idx <= '0;
                    r_state   <= (n_res_cnt == '0) ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (m_fire) begin
                        if (res_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_res_idx <= RES_CNT_W'(r_res_idx + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
